>>> design/wat_pkg.sv
// Shared types, codes and helpers for the weekly alarm table.
package wat_pkg;

  // Default table depth
  localparam int MAX_ENTRIES_DEF = 16;

  // Fixed field widths
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int DAYS_W    = 8;
  localparam int IDX_IN_W  = 4;
  localparam int DAY_W     = 3;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;
  localparam int TOD_W     = 11;

  localparam logic [DAYS_W-1:0] DAY_TOP_BIT  = 8'h80;
  localparam logic [TOD_W-1:0]  MIN_PER_HOUR = 11'd60;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MATCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_INDEX = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MODIFY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DAYS_W-1:0]   weekdays;
  } entry_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;    // rotate the ring by one place
    logic compact;  // cells at or above the target take their neighbor
    logic load;     // the target cell takes the argument entry
  } cell_ctl_t;

  // Minutes since midnight, hour and minute used as given
  function automatic logic [TOD_W-1:0] time_of_day(input logic [HOUR_W-1:0] h,
                                                   input logic [MINUTE_W-1:0] m);
    time_of_day = TOD_W'(h) * MIN_PER_HOUR + TOD_W'(m);
  endfunction

endpackage

>>> design/wat_cell.sv
// One table cell: holds a single alarm entry and passes it to its neighbor.
module wat_cell
  import wat_pkg::*;
#(
  parameter int POS_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [POS_W-1:0] tgt_pos,
  input  entry_t           arg,
  input  entry_t           nbr_in,
  output entry_t           entry_out
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_IDX);

  entry_t entry_r;
  entry_t entry_nxt;

  // Take the neighbor on rotate or on compaction at or above the dropped entry, else load the target
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift || (ctl.compact && (MY_POS >= tgt_pos))) begin
      entry_nxt = nbr_in;
    end else if (ctl.load && (MY_POS == tgt_pos)) begin
      entry_nxt = arg;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

>>> design/weekly_alarm_table_unit.sv
// Weekly alarm table: ring of entry cells with a scan-and-commit controller.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+---------------------------
//  command  | start, busy, in_*                       | start high while busy low
//  result   | out_strobe, out_*                       | out_strobe high, 1 cycle
//
// Every command scans the whole ring: the ring of cells rotates once past the
// head cell, one entry per cycle, while the controller examines it, then a
// commit state writes or compacts the cells as the command needs. The result
// strobes in the cycle after commit, and a new command can be taken in that
// same cycle. Reset clears the entry count and control; cell contents are
// left as they are. The receiver cannot stall the result.
module weekly_alarm_table_unit
  import wat_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [HOUR_W-1:0]   in_hour,
  input  logic [MINUTE_W-1:0] in_minute,
  input  logic [DAYS_W-1:0]   in_weekdays,
  input  logic [IDX_IN_W-1:0] in_index,
  input  logic [HOUR_W-1:0]   in_now_hour,
  input  logic [MINUTE_W-1:0] in_now_minute,
  input  logic [DAY_W-1:0]    in_now_weekday,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_found,
  output logic [HOUR_W-1:0]   out_alarm_hour,
  output logic [MINUTE_W-1:0] out_alarm_minute,
  output logic [DAYS_W-1:0]   out_alarm_weekdays,
  output logic [OUT_CNT_W-1:0] out_alarm_count
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Command registers
  logic [CMD_W-1:0]    cmd_r;
  entry_t              arg_r;
  logic [IDX_IN_W-1:0] idx_r;
  logic [TOD_W-1:0]    now_t_r;
  logic [DAY_W-1:0]    day_r;

  // Scan state
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hit_r, hit_nxt;
  logic [POS_W-1:0] hit_pos_r, hit_pos_nxt;
  logic             found_r, found_nxt;
  entry_t           res_r, res_nxt;
  logic [TOD_W-1:0] best_t_r, best_t_nxt;

  // Result registers
  logic                 out_strobe_r;
  logic [STATUS_W-1:0]  out_status_r, status_nxt;
  logic                 out_found_r;
  entry_t               out_entry_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  // Cell ring
  entry_t           ent [MAX_ENTRIES];
  cell_ctl_t        ctl;
  logic [POS_W-1:0] tgt_pos;
  entry_t           head;
  logic [TOD_W-1:0] head_t;
  logic             in_range, day_on, idx_ok;
  logic [POS_W-1:0] step_pos;
  logic [CMP_W-1:0] idx_ext, cnt_ext, step_ext;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      wat_cell #(
        .POS_W   (POS_W),
        .CELL_IDX(gi)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .tgt_pos  (tgt_pos),
        .arg      (arg_r),
        .nbr_in   (ent[(gi + 1) % MAX_ENTRIES]),
        .entry_out(ent[gi])
      );
    end
  endgenerate

  assign head     = ent[0];
  assign head_t   = time_of_day(head.hour, head.minute);
  assign step_pos = step_r[POS_W-1:0];
  assign idx_ext  = CMP_W'(idx_r);
  assign cnt_ext  = CMP_W'(count_r);
  assign step_ext = CMP_W'(step_r);
  assign in_range = step_r < count_r;
  assign idx_ok   = idx_ext < cnt_ext;
  assign day_on   = (head.weekdays & (DAY_TOP_BIT >> day_r)) != '0;

  // Examine the head cell during the scan, decide the commit at the end
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    count_nxt   = count_r;
    hit_nxt     = hit_r;
    hit_pos_nxt = hit_pos_r;
    found_nxt   = found_r;
    res_nxt     = res_r;
    best_t_nxt  = best_t_r;
    status_nxt  = STS_OK;
    ctl         = '0;
    tgt_pos     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          step_nxt  = '0;
          hit_nxt   = 1'b0;
          found_nxt = 1'b0;
          res_nxt   = '0;
        end
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        step_nxt  = step_r + CNT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
        if (in_range) begin
          case (cmd_r)
            CMD_DEL_MATCH: begin
              if (!hit_r && (head == arg_r)) begin
                hit_nxt     = 1'b1;
                hit_pos_nxt = step_pos;
              end
            end
            CMD_QUERY: begin
              if (day_on && (head_t > now_t_r) && (!found_r || (head_t < best_t_r))) begin
                found_nxt  = 1'b1;
                best_t_nxt = head_t;
                res_nxt    = head;
              end
            end
            CMD_READ: begin
              if (step_ext == idx_ext) begin
                found_nxt = 1'b1;
                res_nxt   = head;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_ADD: begin
            if (count_r >= FULL_CNT) begin
              status_nxt = STS_FULL;
            end else begin
              ctl.load  = 1'b1;
              tgt_pos   = count_r[POS_W-1:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_DEL_MATCH: begin
            if (hit_r) begin
              ctl.compact = 1'b1;
              tgt_pos     = hit_pos_r;
              count_nxt   = count_r - CNT_W'(1);
            end else begin
              status_nxt = STS_NOT_FOUND;
            end
          end
          CMD_DEL_INDEX: begin
            if (idx_ok) begin
              ctl.compact = 1'b1;
              tgt_pos     = idx_ext[POS_W-1:0];
              count_nxt   = count_r - CNT_W'(1);
            end else begin
              status_nxt = STS_RANGE;
            end
          end
          CMD_MODIFY: begin
            if (idx_ok) begin
              ctl.load = 1'b1;
              tgt_pos  = idx_ext[POS_W-1:0];
            end else begin
              status_nxt = STS_RANGE;
            end
          end
          CMD_READ: begin
            if (!idx_ok) begin
              status_nxt = STS_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (state_r == S_DONE);
    end
  end

  // Hold the command and scan results
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      cmd_r   <= in_command;
      arg_r   <= '{hour: in_hour, minute: in_minute, weekdays: in_weekdays};
      idx_r   <= in_index;
      now_t_r <= time_of_day(in_now_hour, in_now_minute);
      day_r   <= in_now_weekday;
    end
    step_r    <= step_nxt;
    hit_r     <= hit_nxt;
    hit_pos_r <= hit_pos_nxt;
    found_r   <= found_nxt;
    res_r     <= res_nxt;
    best_t_r  <= best_t_nxt;
  end

  // Capture the result at commit
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_r;
      out_entry_r  <= res_r;
      out_count_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_alarm_hour     = out_entry_r.hour;
  assign out_alarm_minute   = out_entry_r.minute;
  assign out_alarm_weekdays = out_entry_r.weekdays;
  assign out_alarm_count    = out_count_r;

  // Count never exceeds the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table depth");

  // A result follows only a commit cycle
  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_DONE))
    else $error("result strobe without commit");

  // An accepted command makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");

  // A full report leaves the table full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STS_FULL)) |-> (count_r == FULL_CNT))
    else $error("table full reported with free entries");

  // A found alarm comes only from a query or a read
  a_found_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |-> ((cmd_r == CMD_QUERY) || (cmd_r == CMD_READ)))
    else $error("alarm returned by a non-returning command");

endmodule

>>> test/alarm_table_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the weekly alarm table: shadow table, reply prediction and field compare.
module alarm_table_checker
  import wat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [HOUR_W-1:0]    in_hour,
  input  logic [MINUTE_W-1:0]  in_minute,
  input  logic [DAYS_W-1:0]    in_weekdays,
  input  logic [IDX_IN_W-1:0]  in_index,
  input  logic [HOUR_W-1:0]    in_now_hour,
  input  logic [MINUTE_W-1:0]  in_now_minute,
  input  logic [DAY_W-1:0]     in_now_weekday,
  input  logic                 out_strobe,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic                 out_found,
  input  logic [HOUR_W-1:0]    out_alarm_hour,
  input  logic [MINUTE_W-1:0]  out_alarm_minute,
  input  logic [DAYS_W-1:0]    out_alarm_weekdays,
  input  logic [OUT_CNT_W-1:0] out_alarm_count,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int MINUTES_PER_HOUR = 60;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    entry_t               alarm;
    logic [OUT_CNT_W-1:0] count;
  } alarm_reply_t;

  entry_t       shadow_table [MAX_ENTRIES_DEF];
  int           shadow_count = 0;
  alarm_reply_t replies_due [$];
  int           error_total = 0;

  // Drop one entry and shift the later ones down
  task automatic remove_entry(input int pos);
    shadow_count--;
    for (int i = pos; i < shadow_count; i++) shadow_table[i] = shadow_table[i + 1];
  endtask

  // Apply the command on the input ports to the shadow table and build its reply
  task automatic predict_reply(output alarm_reply_t reply);
    entry_t            arg;
    int                hit;
    int                now_t;
    int                alarm_t;
    int                gap;
    int                best;
    logic [DAYS_W-1:0] day_bit;
    reply = '0;
    arg.hour = in_hour;
    arg.minute = in_minute;
    arg.weekdays = in_weekdays;
    case (in_command)
      CMD_ADD: begin
        if (shadow_count >= MAX_ENTRIES_DEF) reply.status = STS_FULL;
        else begin
          shadow_table[shadow_count] = arg;
          shadow_count++;
        end
      end
      CMD_DEL_MATCH: begin
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_table[i] == arg) hit = i;
        if (hit < 0) reply.status = STS_NOT_FOUND;
        else remove_entry(hit);
      end
      CMD_DEL_INDEX: begin
        if (int'(in_index) >= shadow_count) reply.status = STS_RANGE;
        else remove_entry(int'(in_index));
      end
      CMD_MODIFY: begin
        if (int'(in_index) >= shadow_count) reply.status = STS_RANGE;
        else shadow_table[in_index] = arg;
      end
      CMD_QUERY: begin
        // strictly later today on the selected day; first of equal gaps wins
        day_bit = DAY_TOP_BIT >> in_now_weekday;
        now_t = int'(in_now_hour) * MINUTES_PER_HOUR + int'(in_now_minute);
        best = 0;
        for (int i = 0; i < shadow_count; i++) begin
          alarm_t = int'(shadow_table[i].hour) * MINUTES_PER_HOUR
                  + int'(shadow_table[i].minute);
          if ((shadow_table[i].weekdays & day_bit) != '0 && alarm_t > now_t) begin
            gap = alarm_t - now_t;
            if (!reply.found || gap < best) begin
              reply.found = 1'b1;
              best = gap;
              reply.alarm = shadow_table[i];
            end
          end
        end
      end
      CMD_READ: begin
        if (int'(in_index) >= shadow_count) reply.status = STS_RANGE;
        else begin
          reply.found = 1'b1;
          reply.alarm = shadow_table[in_index];
        end
      end
      default: ;
    endcase
    reply.count = shadow_count[OUT_CNT_W-1:0];
  endtask

  function automatic int field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  // Retire the result transfer first, then queue the reply of a new command transfer
  always @(posedge clk) begin
    alarm_reply_t want;
    alarm_reply_t fresh;
    if (!rst_n) begin
      shadow_count = 0;
      replies_due.delete();
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          error_total++;
        end else begin
          want = replies_due.pop_front();
          error_total += field_differs("status", 8'(want.status), 8'(out_status))
                       + field_differs("found", 8'(want.found), 8'(out_found))
                       + field_differs("alarm_hour", 8'(want.alarm.hour),
                                       8'(out_alarm_hour))
                       + field_differs("alarm_minute", 8'(want.alarm.minute),
                                       8'(out_alarm_minute))
                       + field_differs("alarm_weekdays", want.alarm.weekdays,
                                       out_alarm_weekdays)
                       + field_differs("alarm_count", 8'(want.count),
                                       8'(out_alarm_count));
        end
      end
      if (start && !busy) begin
        predict_reply(fresh);
        replies_due.push_back(fresh);
      end
    end
    mismatches <= error_total;
    outstanding <= replies_due.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Top of the weekly alarm table test: clock, reset, command stimulus, watchdog and verdict.
module testbench;
  import wat_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int TAIL_ITEMS    = 100;
  localparam int SETTLE_CYCLES = 2 * (MAX_ENTRIES_DEF + 2);
  localparam int POOL_DEPTH    = 32;

  // Codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DAYS_W-1:0]   weekdays;
    logic [IDX_IN_W-1:0] index;
    logic [HOUR_W-1:0]   now_hour;
    logic [MINUTE_W-1:0] now_minute;
    logic [DAY_W-1:0]    now_weekday;
  } alarm_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_command = '0;
  logic [HOUR_W-1:0]    in_hour = '0;
  logic [MINUTE_W-1:0]  in_minute = '0;
  logic [DAYS_W-1:0]    in_weekdays = '0;
  logic [IDX_IN_W-1:0]  in_index = '0;
  logic [HOUR_W-1:0]    in_now_hour = '0;
  logic [MINUTE_W-1:0]  in_now_minute = '0;
  logic [DAY_W-1:0]     in_now_weekday = '0;
  logic                 out_strobe;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_found;
  logic [HOUR_W-1:0]    out_alarm_hour;
  logic [MINUTE_W-1:0]  out_alarm_minute;
  logic [DAYS_W-1:0]    out_alarm_weekdays;
  logic [OUT_CNT_W-1:0] out_alarm_count;
  int                   mismatches;
  int                   outstanding;
  int                   idle_cycles = 0;
  entry_t               added_pool [$];

  weekly_alarm_table_unit dut (.*);

  alarm_table_checker scoreboard (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic logic [DAYS_W-1:0] random_mask();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return DAYS_W'($urandom);
    if (pick < 6) return '1;
    if (pick < 8) return DAY_TOP_BIT >> $urandom_range(0, 7);
    if (pick < 9) return '0;
    return ~(DAY_TOP_BIT >> $urandom_range(0, 7));
  endfunction

  // Mostly legal times, a crowded corner for ties and matches, some out-of-range
  function automatic entry_t random_alarm();
    entry_t a;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      a.hour = HOUR_W'($urandom_range(7, 8));
      a.minute = MINUTE_W'(15 * $urandom_range(0, 2));
    end else if (pick < 9) begin
      a.hour = HOUR_W'($urandom_range(0, 23));
      a.minute = MINUTE_W'($urandom_range(0, 59));
    end else begin
      a.hour = HOUR_W'($urandom);
      a.minute = MINUTE_W'($urandom);
    end
    a.weekdays = random_mask();
    return a;
  endfunction

  function automatic alarm_cmd_t random_command(input traffic_mode_t mode);
    alarm_cmd_t c;
    entry_t     a;
    int         roll;
    int         w_add;
    int         w_match;
    int         w_index;
    int         w_modify;
    int         w_query;
    // unused fields stay random so every bit toggles
    c.command = CMD_W'($urandom);
    c.hour = HOUR_W'($urandom);
    c.minute = MINUTE_W'($urandom);
    c.weekdays = DAYS_W'($urandom);
    c.index = IDX_IN_W'($urandom);
    c.now_hour = HOUR_W'($urandom);
    c.now_minute = MINUTE_W'($urandom);
    c.now_weekday = DAY_W'($urandom);
    if ($urandom_range(0, 19) == 0) return c;

    a = random_alarm();
    c.hour = a.hour;
    c.minute = a.minute;
    c.weekdays = a.weekdays;
    c.index = $urandom_range(0, 1) ? IDX_IN_W'($urandom_range(0, 15))
                                   : IDX_IN_W'($urandom_range(0, 4));
    if ($urandom_range(0, 9) != 0) begin
      c.now_hour = HOUR_W'($urandom_range(0, 23));
      c.now_minute = MINUTE_W'($urandom_range(0, 59));
    end

    case (mode)
      MODE_FILL: begin
        w_add = 60; w_match = 65; w_index = 70; w_modify = 76; w_query = 90;
      end
      MODE_DRAIN: begin
        w_add = 15; w_match = 45; w_index = 70; w_modify = 76; w_query = 90;
      end
      default: begin
        w_add = 30; w_match = 45; w_index = 55; w_modify = 65; w_query = 83;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_add) c.command = CMD_ADD;
    else if (roll < w_match) c.command = CMD_DEL_MATCH;
    else if (roll < w_index) c.command = CMD_DEL_INDEX;
    else if (roll < w_modify) c.command = CMD_MODIFY;
    else if (roll < w_query) c.command = CMD_QUERY;
    else if (roll < 97) c.command = CMD_READ;
    else c.command = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;

    // delete matching mostly targets something added earlier
    if (c.command == CMD_DEL_MATCH && added_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
      a = added_pool[$urandom_range(0, added_pool.size() - 1)];
      c.hour = a.hour;
      c.minute = a.minute;
      c.weekdays = a.weekdays;
    end
    if (c.command == CMD_ADD) begin
      added_pool.push_back(a);
      if (added_pool.size() > POOL_DEPTH) void'(added_pool.pop_front());
    end
    return c;
  endfunction

  // Present one command and hold it until the transfer edge
  task automatic drive_command(input alarm_cmd_t c);
    start <= 1'b1;
    in_command <= c.command;
    in_hour <= c.hour;
    in_minute <= c.minute;
    in_weekdays <= c.weekdays;
    in_index <= c.index;
    in_now_hour <= c.now_hour;
    in_now_minute <= c.now_minute;
    in_now_weekday <= c.now_weekday;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [HOUR_W-1:0] h,
                       input logic [MINUTE_W-1:0] m, input logic [DAYS_W-1:0] days,
                       input logic [IDX_IN_W-1:0] idx, input logic [HOUR_W-1:0] nh,
                       input logic [MINUTE_W-1:0] nm, input logic [DAY_W-1:0] nd);
    alarm_cmd_t c;
    c = '{cmd, h, m, days, idx, nh, nm, nd};
    drive_command(c);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every reply has come back
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    traffic_mode_t mode;
    int            span;
    int            sent;
    bit            quiet;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: every index out of range, no match, nothing to find
    issue(CMD_READ, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_DEL_INDEX, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_MODIFY, 5, 5, 8'h0F, 0, 0, 0, 0);
    issue(CMD_DEL_MATCH, 5, 5, 8'h0F, 0, 0, 0, 0);
    issue(CMD_QUERY, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_SPARE_A, 31, 63, 8'hFF, 15, 31, 63, 7);
    issue(CMD_SPARE_B, 31, 63, 8'hFF, 15, 31, 63, 7);
    // extremes, an out-of-range time and two alarms at the same minute
    issue(CMD_ADD, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_ADD, 23, 59, 8'hFF, 0, 0, 0, 0);
    issue(CMD_ADD, 31, 63, 8'h80, 0, 0, 0, 0);
    issue(CMD_ADD, 12, 30, 8'h01, 0, 0, 0, 0);
    issue(CMD_ADD, 12, 30, 8'h81, 0, 0, 0, 0);
    // nearest later alarm, tie at equal gap, strictly later, nothing later
    issue(CMD_QUERY, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_QUERY, 0, 0, 8'h00, 0, 12, 29, 7);
    issue(CMD_QUERY, 0, 0, 8'h00, 0, 12, 30, 7);
    issue(CMD_QUERY, 0, 0, 8'h00, 0, 31, 63, 0);
    issue(CMD_READ, 0, 0, 8'h00, 4, 0, 0, 0);
    issue(CMD_READ, 0, 0, 8'h00, 15, 0, 0, 0);
    issue(CMD_MODIFY, 31, 63, 8'hFF, 1, 0, 0, 0);
    issue(CMD_DEL_MATCH, 12, 30, 8'h01, 0, 0, 0, 0);
    issue(CMD_DEL_MATCH, 12, 30, 8'h01, 0, 0, 0, 0);
    issue(CMD_DEL_INDEX, 0, 0, 8'h00, 0, 0, 0, 0);
    issue(CMD_READ, 0, 0, 8'h00, 0, 0, 0, 0);
    drain_replies();

    // random traffic in stretches that fill, drain or churn the table
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = traffic_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        drive_command(random_command(mode));
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_replies();
        else if (!quiet && sent < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 2) == 0)
          hold_off($urandom_range(1, 18));
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> weekly_alarm_table_unit.f
design/wat_pkg.sv
design/wat_cell.sv
design/weekly_alarm_table_unit.sv
test/alarm_table_checker.sv
test/testbench.sv
